// ----- sv/upspde_pkg.sv -----
// ----------------------------------------------------------------------------
// upspde_pkg
// Shared constants and types for the UPS patch XOR-delta body encoder.
// ----------------------------------------------------------------------------
package upspde_pkg;

  // Default width of the position and gap counters
  localparam int SIZE_BITS_DEF = 32;

  // Register port
  localparam int PADDR_W = 3;
  localparam int DATA_W  = 32;

  typedef logic [PADDR_W-1:0] paddr_t;
  typedef logic [DATA_W-1:0]  data_t;

  // Register index, taken from paddr[2]
  localparam logic [0:0] REG_BASE_LENGTH = 1'b0;

  // Emitter phase codes
  typedef logic [1:0] phase_t;
  localparam phase_t PH_GAP  = 2'd0;  // gap varint bytes
  localparam phase_t PH_DIFF = 2'd1;  // XOR byte
  localparam phase_t PH_TERM = 2'd2;  // run terminator

  localparam logic [7:0] BYTE_TERM = 8'h00;

endpackage

// ----- sv/ups_patch_diff_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// ups_patch_diff_encoder_unit
// UPS patch body encoder: XOR-delta runs separated by varint-coded gaps.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+---------------------------------
//  in       | sink      | in_valid / in_stall | in_patched_byte, in_base_byte,
//           |           |                     | in_final_byte
//  out      | source    | out_valid/out_stall | out_patch_byte, out_last_of_item
//  register | slave     | psel/penable/pready | paddr, pwdata, prdata
//
//  An input transfer updates the file state and, if the item has output, posts
//  its job (varint gap, XOR byte, terminator) in the pending register;
//  out_valid rises once the job moves on into the active emitter register.
//  One byte per cycle while out_stall is low; an item has at most 7 bytes at SIZE_BITS 32.
//  rst_n is synchronous: clears counters, run flag, queues and base_length.
//  out_stall holds the emitter; a full pending register then raises in_stall,
//  also for items with no output, until the current item's last byte goes.
//
module ups_patch_diff_encoder_unit #(
  parameter int SIZE_BITS = upspde_pkg::SIZE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  upspde_pkg::paddr_t  paddr,
  input  upspde_pkg::data_t   pwdata,
  output upspde_pkg::data_t   prdata,
  output logic                pready,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_patched_byte,
  input  logic [7:0]          in_base_byte,
  input  logic                in_final_byte,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_patch_byte,
  output logic                out_last_of_item
);

  // compare width for position against the 32-bit base length
  localparam int CMP_W = (SIZE_BITS > 32) ? SIZE_BITS : 32;

  localparam logic [SIZE_BITS-1:0] CNT_MAX = {SIZE_BITS{1'b1}};
  localparam logic [SIZE_BITS-1:0] CNT_ONE = SIZE_BITS'(1);

  // --------------------------------------------------------------------------
  // Register port
  // --------------------------------------------------------------------------
  logic [31:0] base_length_r;
  logic [0:0]  reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel & penable & pwrite;
  assign prdata  = (reg_idx == upspde_pkg::REG_BASE_LENGTH) ? base_length_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_length_r <= '0;
    end else if (cfg_wr && reg_idx == upspde_pkg::REG_BASE_LENGTH) begin
      base_length_r <= pwdata;
    end
  end

  // --------------------------------------------------------------------------
  // File state and job decode
  // --------------------------------------------------------------------------
  logic [SIZE_BITS-1:0] pos_r, pos_nxt;
  logic [SIZE_BITS-1:0] gap_r, gap_nxt;
  logic                 in_run_r, in_run_nxt;

  logic                 in_fire;
  logic                 base_ok;
  logic [7:0]           diff;
  logic                 job_has;
  upspde_pkg::phase_t   job_ph;

  assign in_fire = in_valid & ~in_stall;
  assign base_ok = CMP_W'(pos_r) < CMP_W'(base_length_r);
  assign diff    = in_patched_byte ^ (base_ok ? in_base_byte : 8'h00);

  always_comb begin
    job_has    = 1'b0;
    job_ph     = upspde_pkg::PH_DIFF;
    gap_nxt    = gap_r;
    in_run_nxt = in_run_r;
    pos_nxt    = pos_r;

    if (!in_run_r) begin
      if (diff == 8'h00) begin
        if (gap_r != CNT_MAX) gap_nxt = gap_r + CNT_ONE;
      end else begin
        // run opens: gap varint, then XOR byte
        job_has    = 1'b1;
        job_ph     = upspde_pkg::PH_GAP;
        gap_nxt    = '0;
        in_run_nxt = 1'b1;
      end
    end else if (diff == 8'h00) begin
      // equal byte closes the run and is consumed
      job_has    = 1'b1;
      job_ph     = upspde_pkg::PH_TERM;
      gap_nxt    = '0;
      in_run_nxt = 1'b0;
    end else begin
      job_has = 1'b1;
    end

    // end of file: start over for the next file
    if (in_final_byte) begin
      pos_nxt    = '0;
      gap_nxt    = '0;
      in_run_nxt = 1'b0;
    end else if (pos_r != CNT_MAX) begin
      pos_nxt = pos_r + CNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      gap_r    <= '0;
      in_run_r <= 1'b0;
    end else if (in_fire) begin
      pos_r    <= pos_nxt;
      gap_r    <= gap_nxt;
      in_run_r <= in_run_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Pending job register
  // --------------------------------------------------------------------------
  logic                 pend_vld_r, pend_vld_nxt;
  upspde_pkg::phase_t   pend_ph_r;
  logic [SIZE_BITS-1:0] pend_gap_r;
  logic [7:0]           pend_diff_r;
  logic                 pend_term_r;
  logic                 pend_load;

  // emitter handshake terms
  logic                 act_vld_r, act_vld_nxt;
  upspde_pkg::phase_t   act_ph_r, act_ph_nxt;
  logic [SIZE_BITS-1:0] act_gap_r, act_gap_nxt;
  logic [7:0]           act_diff_r, act_diff_nxt;
  logic                 act_term_r, act_term_nxt;
  logic                 act_last;
  logic                 out_fire;
  logic                 load_act;

  assign out_fire  = act_vld_r & ~out_stall;
  assign load_act  = pend_vld_r & (~act_vld_r | (out_fire & act_last));
  assign in_stall  = pend_vld_r & ~load_act;
  assign pend_load = in_fire & job_has;

  always_comb begin
    pend_vld_nxt = pend_vld_r;
    if (pend_load)     pend_vld_nxt = 1'b1;
    else if (load_act) pend_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
    end else begin
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_load) begin
      pend_ph_r   <= job_ph;
      pend_gap_r  <= gap_r;
      pend_diff_r <= diff;
      pend_term_r <= in_final_byte;
    end
  end

  // --------------------------------------------------------------------------
  // Emitter: while out_stall is low, one patch byte per cycle
  // --------------------------------------------------------------------------
  logic [SIZE_BITS-1:0] gap_rem;
  logic                 rem_zero;

  assign gap_rem  = act_gap_r >> 7;
  assign rem_zero = (gap_rem == '0);

  always_comb begin
    case (act_ph_r)
      upspde_pkg::PH_GAP: begin
        out_patch_byte = {rem_zero, act_gap_r[6:0]};
        act_last       = 1'b0;
      end
      upspde_pkg::PH_DIFF: begin
        out_patch_byte = act_diff_r;
        act_last       = ~act_term_r;
      end
      upspde_pkg::PH_TERM: begin
        out_patch_byte = upspde_pkg::BYTE_TERM;
        act_last       = 1'b1;
      end
      default: begin
        out_patch_byte = upspde_pkg::BYTE_TERM;
        act_last       = 1'b1;
      end
    endcase
  end

  assign out_valid        = act_vld_r;
  assign out_last_of_item = act_last;

  always_comb begin
    act_vld_nxt  = act_vld_r;
    act_ph_nxt   = act_ph_r;
    act_gap_nxt  = act_gap_r;
    act_diff_nxt = act_diff_r;
    act_term_nxt = act_term_r;

    if (load_act) begin
      act_vld_nxt  = 1'b1;
      act_ph_nxt   = pend_ph_r;
      act_gap_nxt  = pend_gap_r;
      act_diff_nxt = pend_diff_r;
      act_term_nxt = pend_term_r;
    end else if (out_fire) begin
      if (act_last) act_vld_nxt = 1'b0;
      case (act_ph_r)
        upspde_pkg::PH_GAP: begin
          // varint: minus-one continuation between 7-bit groups
          if (rem_zero) act_ph_nxt = upspde_pkg::PH_DIFF;
          else          act_gap_nxt = gap_rem - CNT_ONE;
        end
        upspde_pkg::PH_DIFF: begin
          if (act_term_r) act_ph_nxt = upspde_pkg::PH_TERM;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_vld_r <= 1'b0;
      act_ph_r  <= upspde_pkg::PH_TERM;
    end else begin
      act_vld_r <= act_vld_nxt;
      act_ph_r  <= act_ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_gap_r  <= act_gap_nxt;
    act_diff_r <= act_diff_nxt;
    act_term_r <= act_term_nxt;
  end

endmodule

// ----- sv/upspde_checker.sv -----
// ----------------------------------------------------------------------------
// upspde_checker
// Port-level checks for the UPS patch body encoder, bound to the top level.
// ----------------------------------------------------------------------------
module upspde_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       pready,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_patch_byte,
  input logic       out_last_of_item
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_patch_byte)
                               && $stable(out_last_of_item))
    else $error("result changed while stalled");

  // input only backs up behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("in_stall with no result waiting");

  // an item's bytes come without a gap
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_item |=> out_valid)
    else $error("result burst broken before last byte");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("activity right after reset");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind ups_patch_diff_encoder_unit upspde_checker u_upspde_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .pready           (pready),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_patch_byte   (out_patch_byte),
  .out_last_of_item (out_last_of_item)
);
